// ===== hw/rtl/whsp_pkg.sv =====
// Shared types, tag constants and field-length table for the WAV header stream parser.
package whsp_pkg;

  typedef enum logic [4:0] {
    PH_RIFF    = 5'd0,
    PH_RSIZE   = 5'd1,
    PH_WAVE    = 5'd2,
    PH_FMT     = 5'd3,
    PH_FSIZE   = 5'd4,
    PH_FORMAT  = 5'd5,
    PH_CHAN    = 5'd6,
    PH_RATE    = 5'd7,
    PH_BRATE   = 5'd8,
    PH_ALIGN   = 5'd9,
    PH_BITS    = 5'd10,
    PH_EXT     = 5'd11,
    PH_VALID   = 5'd12,
    PH_MASK    = 5'd13,
    PH_SUB     = 5'd14,
    PH_SKIP    = 5'd15,
    PH_DTAG    = 5'd16,
    PH_DSIZE   = 5'd17,
    PH_PAYLOAD = 5'd18,
    PH_DONE    = 5'd19
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_RIFF  = 3'd1,
    ST_BAD_WAVE  = 3'd2,
    ST_BAD_FMT   = 3'd3,
    ST_BAD_DATA  = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  // Tags as little-endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BASE = 32'd16;
  localparam logic [15:0] EXT_FULL = 16'd22;
  localparam logic [15:0] FMT_PCM  = 16'h0001;
  localparam logic [15:0] FMT_EXT  = 16'hFFFE;

  function automatic logic [4:0] field_len(phase_t ph);
    logic [4:0] len;
    case (ph)
      PH_FORMAT, PH_CHAN, PH_ALIGN, PH_BITS, PH_EXT, PH_VALID: len = 5'd2;
      PH_SUB:                                                  len = 5'd16;
      default:                                                 len = 5'd4;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/whsp_stream_if.sv =====
// Valid/ready channel interfaces: file byte input and parse result output.
interface whsp_byte_if import whsp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       first_byte;
  logic       final_byte;

  modport source (output valid, byte_value, first_byte, final_byte, input ready);
  modport sink   (input valid, byte_value, first_byte, final_byte, output ready);
endinterface

interface whsp_result_if import whsp_pkg::*; ();
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [7:0]  payload_byte;
  logic [15:0] format_tag;
  logic [15:0] channel_count;
  logic [31:0] samples_per_sec;
  logic [31:0] byte_rate;
  logic [15:0] frame_bytes;
  logic [15:0] sample_width;
  logic [31:0] payload_size;
  status_t     status;
  logic        format_unsupported;
  logic        last_payload;

  modport source (
    output valid, kind, payload_byte, format_tag, channel_count, samples_per_sec, byte_rate,
           frame_bytes, sample_width, payload_size, status, format_unsupported,
           last_payload,
    input  ready
  );
  modport sink (
    input  valid, kind, payload_byte, format_tag, channel_count, samples_per_sec, byte_rate,
           frame_bytes, sample_width, payload_size, status, format_unsupported,
           last_payload,
    output ready
  );
endinterface

// ===== hw/rtl/wav_header_stream_parser_core.sv =====
// WAV header stream parser: walks RIFF/WAVE chunks byte by byte and passes payload bytes out.
//
// file_stream: one WAV file byte per transaction; first_byte restarts parsing at that
//   byte, final_byte marks the end of the file buffer.
// result: one transaction per input byte: kind (header, payload, error), the payload
//   byte, the format fields parsed so far, payload size, status and last_payload.
// The result is registered, so it appears in the cycle after the byte is taken.
// Throughput: one byte per cycle while the receiver keeps up. Parse state updates in
//   a single pass between the input handshake and the result register; the format
//   fields are read directly from the parse registers, which always match the result being shown.
// Stall: file_stream.ready is high while the result register is empty or being
//   taken in the same cycle; while the receiver holds off, the result waits and
//   no byte is taken.
// Reset: rst clears all parse state (expecting the RIFF tag, all fields zero) and
//   empties the result register. Errors are sticky until a byte with first_byte.
module wav_header_stream_parser_core import whsp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  whsp_byte_if.sink     file_stream,
  whsp_result_if.source result
);

  phase_t      phase, cur_phase, phase_next;
  logic [4:0]  byte_position, cur_pos, pos_next, pos_inc;
  logic [31:0] assembly_word, cur_word, word_next, asm_word;
  logic [31:0] fmt_chunk_size, cur_fsize, fsize_next;
  logic [15:0] skip_remaining, cur_skip, skip_next;
  logic [31:0] payload_remaining, cur_prem, prem_next;
  logic [15:0] format_tag_reg, cur_tag, tag_next;
  logic [15:0] channels_reg, cur_chan, chan_next;
  logic [31:0] rate_reg, cur_rate, rate_next;
  logic [31:0] byte_rate_reg, cur_brate, brate_next;
  logic [15:0] align_reg, cur_align, align_next;
  logic [15:0] sample_bits_reg, cur_bits, bits_next;
  logic [31:0] data_length_reg, cur_dlen, dlen_next;
  status_t     error_code, cur_err, err_next;
  logic        unsupported_flag, cur_unsup, unsup_next;

  logic        field_end;
  logic        fmt_end;
  logic        in_accept;
  logic        out_valid;
  kind_t       kind_reg, kind_next;
  logic [7:0]  pbyte_reg, pbyte_next;
  logic        lastp_reg, lastp_next;

  assign file_stream.ready = !out_valid || result.ready;
  assign in_accept         = file_stream.valid && file_stream.ready;

  // Restart: parse this byte from reset state
  always_comb begin
    if (file_stream.first_byte) begin
      cur_phase = PH_RIFF;
      cur_pos   = '0;
      cur_word  = '0;
      cur_fsize = '0;
      cur_skip  = '0;
      cur_prem  = '0;
      cur_tag   = '0;
      cur_chan  = '0;
      cur_rate  = '0;
      cur_brate = '0;
      cur_align = '0;
      cur_bits  = '0;
      cur_dlen  = '0;
      cur_err   = ST_OK;
      cur_unsup = 1'b0;
    end else begin
      cur_phase = phase;
      cur_pos   = byte_position;
      cur_word  = assembly_word;
      cur_fsize = fmt_chunk_size;
      cur_skip  = skip_remaining;
      cur_prem  = payload_remaining;
      cur_tag   = format_tag_reg;
      cur_chan  = channels_reg;
      cur_rate  = rate_reg;
      cur_brate = byte_rate_reg;
      cur_align = align_reg;
      cur_bits  = sample_bits_reg;
      cur_dlen  = data_length_reg;
      cur_err   = error_code;
      cur_unsup = unsupported_flag;
    end
  end

  // Little-endian field assembly
  always_comb begin
    asm_word = cur_word;
    if (cur_pos < 5'd4) begin
      asm_word[{cur_pos[1:0], 3'b000} +: 8] =
        cur_word[{cur_pos[1:0], 3'b000} +: 8] | file_stream.byte_value;
    end
    pos_inc   = cur_pos + 5'd1;
    field_end = (pos_inc >= field_len(cur_phase));
  end

  // Next state
  always_comb begin
    phase_next = cur_phase;
    pos_next   = cur_pos;
    word_next  = cur_word;
    fsize_next = cur_fsize;
    skip_next  = cur_skip;
    prem_next  = cur_prem;
    tag_next   = cur_tag;
    chan_next  = cur_chan;
    rate_next  = cur_rate;
    brate_next = cur_brate;
    align_next = cur_align;
    bits_next  = cur_bits;
    dlen_next  = cur_dlen;
    err_next   = cur_err;
    unsup_next = cur_unsup;
    fmt_end    = 1'b0;

    if (cur_err == ST_OK) begin
      unique case (cur_phase)
        PH_PAYLOAD: begin
          prem_next = cur_prem - 32'd1;
          if (prem_next == '0) begin
            phase_next = PH_DONE;
          end
        end
        PH_SKIP: begin
          skip_next = cur_skip - 16'd1;
          if (skip_next == '0) begin
            fmt_end = 1'b1;
          end
        end
        PH_DONE: begin
        end
        default: begin
          if (field_end) begin
            pos_next  = '0;
            word_next = '0;
            unique case (cur_phase)
              PH_RIFF: begin
                if (asm_word == TAG_RIFF) phase_next = PH_RSIZE;
                else                      err_next   = ST_BAD_RIFF;
              end
              PH_RSIZE: phase_next = PH_WAVE;
              PH_WAVE: begin
                if (asm_word == TAG_WAVE) phase_next = PH_FMT;
                else                      err_next   = ST_BAD_WAVE;
              end
              PH_FMT: begin
                if (asm_word == TAG_FMT) phase_next = PH_FSIZE;
                else                     err_next   = ST_BAD_FMT;
              end
              PH_FSIZE: begin
                fsize_next = asm_word;
                phase_next = PH_FORMAT;
              end
              PH_FORMAT: begin
                tag_next   = asm_word[15:0];
                phase_next = PH_CHAN;
              end
              PH_CHAN: begin
                chan_next  = asm_word[15:0];
                phase_next = PH_RATE;
              end
              PH_RATE: begin
                rate_next  = asm_word;
                phase_next = PH_BRATE;
              end
              PH_BRATE: begin
                brate_next = asm_word;
                phase_next = PH_ALIGN;
              end
              PH_ALIGN: begin
                align_next = asm_word[15:0];
                phase_next = PH_BITS;
              end
              PH_BITS: begin
                bits_next = asm_word[15:0];
                if (cur_fsize > FMT_BASE) phase_next = PH_EXT;
                else                      fmt_end    = 1'b1;
              end
              PH_EXT: begin
                priority if (asm_word[15:0] == EXT_FULL) begin
                  phase_next = PH_VALID;
                end else if (asm_word[15:0] == '0) begin
                  fmt_end = 1'b1;
                end else begin
                  skip_next  = asm_word[15:0];
                  phase_next = PH_SKIP;
                end
              end
              PH_VALID: begin
                bits_next  = asm_word[15:0];
                phase_next = PH_MASK;
              end
              PH_MASK: phase_next = PH_SUB;
              PH_SUB:  fmt_end    = 1'b1;
              PH_DTAG: begin
                if (asm_word == TAG_DATA) phase_next = PH_DSIZE;
                else                      err_next   = ST_BAD_DATA;
              end
              PH_DSIZE: begin
                dlen_next  = asm_word;
                prem_next  = asm_word;
                phase_next = (asm_word == '0) ? PH_DONE : PH_PAYLOAD;
              end
              default: begin
              end
            endcase
          end else begin
            pos_next  = pos_inc;
            word_next = asm_word;
          end
        end
      endcase

      if (fmt_end) begin
        unsup_next = ((tag_next != FMT_PCM) && (tag_next != FMT_EXT)) ||
                     (bits_next[2:0] != 3'd0);
        phase_next = PH_DTAG;
      end

      if ((err_next == ST_OK) && file_stream.final_byte && (phase_next != PH_DONE)) begin
        err_next = ST_TRUNCATED;
      end
    end
  end

  // Result outputs
  always_comb begin
    kind_next  = KIND_HEADER;
    pbyte_next = '0;
    lastp_next = 1'b0;
    if (err_next != ST_OK) begin
      kind_next = KIND_ERROR;
    end else if (cur_phase == PH_PAYLOAD) begin
      kind_next  = KIND_PAYLOAD;
      pbyte_next = file_stream.byte_value;
      lastp_next = (phase_next == PH_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_RIFF;
      byte_position     <= '0;
      assembly_word     <= '0;
      fmt_chunk_size    <= '0;
      skip_remaining    <= '0;
      payload_remaining <= '0;
      format_tag_reg    <= '0;
      channels_reg      <= '0;
      rate_reg          <= '0;
      byte_rate_reg     <= '0;
      align_reg         <= '0;
      sample_bits_reg   <= '0;
      data_length_reg   <= '0;
      error_code        <= ST_OK;
      unsupported_flag  <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (in_accept) begin
        phase             <= phase_next;
        byte_position     <= pos_next;
        assembly_word     <= word_next;
        fmt_chunk_size    <= fsize_next;
        skip_remaining    <= skip_next;
        payload_remaining <= prem_next;
        format_tag_reg    <= tag_next;
        channels_reg      <= chan_next;
        rate_reg          <= rate_next;
        byte_rate_reg     <= brate_next;
        align_reg         <= align_next;
        sample_bits_reg   <= bits_next;
        data_length_reg   <= dlen_next;
        error_code        <= err_next;
        unsupported_flag  <= unsup_next;
      end
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_reg  <= kind_next;
      pbyte_reg <= pbyte_next;
      lastp_reg <= lastp_next;
    end
  end

  assign result.valid              = out_valid;
  assign result.kind               = kind_reg;
  assign result.payload_byte       = pbyte_reg;
  assign result.last_payload       = lastp_reg;
  assign result.format_tag         = format_tag_reg;
  assign result.channel_count      = channels_reg;
  assign result.samples_per_sec    = rate_reg;
  assign result.byte_rate          = byte_rate_reg;
  assign result.frame_bytes        = align_reg;
  assign result.sample_width       = sample_bits_reg;
  assign result.payload_size       = data_length_reg;
  assign result.status             = error_code;
  assign result.format_unsupported = unsupported_flag;

`ifndef ASSERT_OFF
  a_kind_matches_status: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.kind == KIND_ERROR) == (error_code != ST_OK)))
    else $error("result kind disagrees with status");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !file_stream.first_byte && (error_code != ST_OK))
      |=> ((result.kind == KIND_ERROR) && $stable(error_code)))
    else $error("error did not stick");

  a_payload_countdown: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !file_stream.first_byte && (phase == PH_PAYLOAD) &&
     (error_code == ST_OK))
      |=> (payload_remaining == ($past(payload_remaining) - 32'd1)))
    else $error("payload count did not step down");

  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |-> (payload_remaining == '0))
    else $error("finished with payload outstanding");
`endif

endmodule
